// ----- rtl/core/cdfr_pkg.sv -----
// shared types, constants and window rewrite tables for the csv date reorder block
package cdfr_pkg;

  localparam logic [7:0] SEMI = 8'h3B;

  localparam logic [2:0] REG_NO_DASH    = 3'd0;
  localparam logic [2:0] REG_TIMESTAMP  = 3'd1;
  localparam logic [2:0] REG_SEP_PER_ROW = 3'd2;
  localparam logic [2:0] REG_COL_FIRST  = 3'd3;
  localparam logic [2:0] REG_COL_SECOND = 3'd4;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_DASH    = 2'd0;
  localparam kind_t KIND_NODASH  = 2'd1;
  localparam kind_t KIND_TS_DASH = 2'd2;
  localparam kind_t KIND_TS_NODASH = 2'd3;

  localparam int MAP_LEN = 26;

  // entry with bit 8 set is a literal byte, otherwise a window index
  localparam logic [8:0] WIN_MAP [4][MAP_LEN] = '{
    '{9'd6, 9'd7, 9'd8, 9'd9, 9'h12D, 9'd3, 9'd4, 9'h12D, 9'd0, 9'd1,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd4, 9'd5, 9'd6, 9'd7, 9'd2, 9'd3, 9'd0, 9'd1, 9'd0, 9'd0,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
    '{9'd6, 9'd7, 9'd8, 9'd9, 9'h12D, 9'd3, 9'd4, 9'h12D, 9'd0, 9'd1,
      9'h120, 9'd11, 9'd12, 9'h13A, 9'd14, 9'd15, 9'h13A, 9'h130, 9'h130, 9'h12E,
      9'h130, 9'h130, 9'h130, 9'h130, 9'h130, 9'h130},
    '{9'd4, 9'd5, 9'd6, 9'd7, 9'd2, 9'd3, 9'd0, 9'd1, 9'd8, 9'd9,
      9'd10, 9'd11, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
      9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0}
  };

  typedef struct packed {
    logic  load;
    logic  raw;
    logic  shift;
    kind_t kind;
  } cell_ctrl_t;

  function automatic logic [4:0] win_len(input kind_t k);
    logic [4:0] len;
    case (k)
      KIND_DASH:      len = 5'd10;
      KIND_NODASH:    len = 5'd8;
      KIND_TS_DASH:   len = 5'd26;
      KIND_TS_NODASH: len = 5'd12;
      default:        len = 5'd10;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] map_entry(input kind_t k, input int unsigned idx);
    logic [8:0] ent;
    ent = 9'd0;
    if (idx < MAP_LEN) begin
      ent = WIN_MAP[k][idx];
    end
    return ent;
  endfunction

endpackage

// ----- rtl/core/cdfr_cell.sv -----
// one window cell: a stored window byte and an output shift byte
module cdfr_cell #(
  parameter int IDX   = 0,
  parameter int DEPTH = 26
) (
  input  logic                clk,
  input  cdfr_pkg::cell_ctrl_t ctrl,
  input  logic                wr_en,
  input  logic [7:0]          wr_data,
  input  logic [7:0]          src [DEPTH],
  input  logic [7:0]          shift_in,
  output logic [7:0]          win_q,
  output logic [7:0]          emit_q
);
  import cdfr_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic [8:0] ent;
  logic [7:0] load_val;

  always_comb begin
    ent = map_entry(ctrl.kind, IDX);
    if (ctrl.raw) begin
      load_val = src[IDX];
    end else if (ent[8]) begin
      load_val = ent[7:0];
    end else if (int'(ent[7:0]) < DEPTH) begin
      load_val = src[ent[IW-1:0]];
    end else begin
      load_val = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_q <= wr_data;
    end
    if (ctrl.load) begin
      emit_q <= load_val;
    end else if (ctrl.shift) begin
      emit_q <= shift_in;
    end
  end

endmodule

// ----- rtl/core/csv_date_field_reorder.sv -----
// top level: csv body byte stream with date field reordering
//
//  channel | handshake              | payload
//  s       | s_tvalid / s_tready    | s_tdata = data_byte, s_tlast = end_of_data
//  m       | m_tvalid / m_tready    | m_tdata = out_byte,  m_tlast = run_last
//  cfg     | cfg_we                 | cfg_index, cfg_data
//
// ordinary bytes and window bytes that produce no result do not hold off the input
// a completed or flushed window leaves the cell row one byte per cycle while the output
// is free, and the input is held off for that burst
// one output register; input is taken when it is empty or being drained and no burst runs
// rst is synchronous and clears control state and the config registers to their defaults
module csv_date_field_reorder #(
  parameter int MAX_WINDOW = 26
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import cdfr_pkg::*;

  localparam int FW = $clog2(MAX_WINDOW + 1);

  logic       no_dash;
  logic       timestamp_mode;
  logic [7:0] sep_per_row;
  logic [7:0] col_first;
  logic [7:0] col_second;

  logic [7:0]    sep_count;
  logic [FW-1:0] fill;
  logic          awaiting;
  logic          collecting;
  kind_t         kind_r;
  logic          burst;
  logic          burst_eod;
  logic [FW-1:0] remaining;

  logic [7:0] win  [MAX_WINDOW];
  logic [7:0] emit [MAX_WINDOW];
  logic [7:0] src  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] win_we;

  logic          accept;
  logic          out_free;
  kind_t         kind_cur;
  kind_t         take_kind;
  logic          open_ok;
  logic          opening;
  logic          take;
  logic [FW-1:0] take_fill;
  logic [FW:0]   fill_inc;
  logic          full;
  logic          emit_go;
  logic [7:0]    pass_cnt;
  logic          hit;
  cell_ctrl_t    ctrl;

  function automatic logic [7:0] count_upd(input logic [7:0] cnt, input logic [7:0] b,
                                           input logic [7:0] spr);
    logic [7:0] r;
    r = cnt;
    if (b == SEMI) begin
      r = cnt + 8'd1;
    end else if (cnt == spr) begin
      r = 8'd0;
    end
    return r;
  endfunction

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !burst && out_free;
  assign accept   = s_tvalid && s_tready;
  assign emit_go  = burst && out_free;

  always_comb begin
    kind_cur  = {timestamp_mode, no_dash};
    open_ok   = int'(win_len(kind_cur)) <= MAX_WINDOW;
    opening   = !collecting && awaiting && (s_tdata != SEMI) && open_ok;
    take      = collecting || opening;
    take_kind = collecting ? kind_r : kind_cur;
    take_fill = collecting ? fill : '0;
    fill_inc  = {1'b0, take_fill} + 1'b1;
    full      = int'(fill_inc) >= int'(win_len(take_kind));
    pass_cnt  = count_upd(sep_count, s_tdata, sep_per_row);
    hit       = (s_tdata == SEMI) &&
                (((col_first != 8'd0) && (pass_cnt == col_first)) ||
                 ((col_second != 8'd0) && (pass_cnt == col_second)));
    ctrl.load  = accept && take && (full || s_tlast);
    ctrl.raw   = !full;
    ctrl.shift = emit_go;
    ctrl.kind  = take_kind;
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [7:0] shift_in;

    assign win_we[i] = accept && take && (take_fill == FW'(i));
    assign src[i]    = (take_fill == FW'(i)) ? s_tdata : win[i];

    if (i == MAX_WINDOW - 1) begin : g_end
      assign shift_in = 8'h00;
    end else begin : g_mid
      assign shift_in = emit[i+1];
    end

    cdfr_cell #(
      .IDX  (i),
      .DEPTH(MAX_WINDOW)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .wr_en   (win_we[i]),
      .wr_data (s_tdata),
      .src     (src),
      .shift_in(shift_in),
      .win_q   (win[i]),
      .emit_q  (emit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      no_dash        <= 1'b0;
      timestamp_mode <= 1'b0;
      sep_per_row    <= 8'd0;
      col_first      <= 8'd4;
      col_second     <= 8'd5;
      sep_count      <= 8'd0;
      fill           <= '0;
      awaiting       <= 1'b0;
      collecting     <= 1'b0;
      kind_r         <= KIND_DASH;
      burst          <= 1'b0;
      burst_eod      <= 1'b0;
      remaining      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NO_DASH:     no_dash        <= cfg_data[0];
          REG_TIMESTAMP:   timestamp_mode <= cfg_data[0];
          REG_SEP_PER_ROW: sep_per_row    <= cfg_data;
          REG_COL_FIRST:   col_first      <= cfg_data;
          REG_COL_SECOND:  col_second     <= cfg_data;
          default: ;
        endcase
      end

      if (emit_go) begin
        m_tvalid  <= 1'b1;
        m_tdata   <= emit[0];
        m_tlast   <= (remaining == FW'(1));
        remaining <= remaining - 1'b1;
        if (remaining == FW'(1)) begin
          burst <= 1'b0;
        end
        if (!burst_eod) begin
          sep_count <= count_upd(sep_count, emit[0], sep_per_row);
        end
      end else if (accept && !take) begin
        m_tvalid <= 1'b1;
        m_tdata  <= s_tdata;
        m_tlast  <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (accept) begin
        awaiting <= !take && !s_tlast && hit;
        if (take) begin
          if (opening) begin
            kind_r <= kind_cur;
          end
          if (full || s_tlast) begin
            burst      <= 1'b1;
            burst_eod  <= s_tlast;
            remaining  <= full ? FW'(win_len(take_kind)) : fill_inc[FW-1:0];
            collecting <= 1'b0;
            fill       <= '0;
          end else begin
            collecting <= 1'b1;
            fill       <= fill_inc[FW-1:0];
          end
        end
        if (s_tlast) begin
          sep_count <= 8'd0;
        end else if (!take) begin
          sep_count <= pass_cnt;
        end
      end
    end
  end

endmodule
